>>> src/dssc_pkg.sv
// Shared types and codes of the dirty-state shadow cache.
package dssc_pkg;

   localparam int NUM_TYPES_DEF    = 32;
   localparam int HANDLE_WIDTH_DEF = 32;
   localparam int MAX_RESULTS      = 32;
   localparam int QUEUE_DEPTH      = 2;

   localparam int REQ_W   = 3;
   localparam int SLOT_W  = 5;
   localparam int HDL_W   = 32;
   localparam int CNT_W   = 6;
   localparam int IN_DW   = 72;
   localparam int OUT_DW  = 80;

   // request codes on the port
   localparam logic [REQ_W-1:0] REQ_BIND        = 3'd0;
   localparam logic [REQ_W-1:0] REQ_RESET_ONE   = 3'd1;
   localparam logic [REQ_W-1:0] REQ_RESET_ALL   = 3'd2;
   localparam logic [REQ_W-1:0] REQ_FLUSH       = 3'd3;
   localparam logic [REQ_W-1:0] REQ_SET_DEFAULT = 3'd4;
   // internal code: answer with an empty result, touch nothing
   localparam logic [REQ_W-1:0] OP_NOP          = 3'd5;

   typedef struct packed {
      logic [REQ_W-1:0]  op;
      logic [SLOT_W-1:0] slot;
      logic [HDL_W-1:0]  cmd;
      logic [HDL_W-1:0]  dat;
   } work_type;

   typedef struct packed {
      logic     valid;
      work_type work;
   } queue_head_type;

endpackage

>>> src/dssc_front.sv
// Front end: accepts request beats, classifies them and queues them for the back end.
module dssc_front #(
   parameter int NUM_TYPES = dssc_pkg::NUM_TYPES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [dssc_pkg::REQ_W-1:0]    req_tuser,  // req_type
   input  logic [dssc_pkg::IN_DW-1:0]    req_tdata,  // state_type, command_handle, data_handle
   output dssc_pkg::queue_head_type      head,
   input  logic                          pop
);
   import dssc_pkg::*;

   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   work_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     cnt_ff, cnt_in;
   work_type              item;
   logic                  in_range;
   logic                  push;

   // classify: out-of-range and unknown requests collapse to a no-op
   always_comb begin
      item.slot = req_tdata[SLOT_W-1:0];
      item.cmd  = req_tdata[SLOT_W+HDL_W-1:SLOT_W];
      item.dat  = req_tdata[SLOT_W+2*HDL_W-1:SLOT_W+HDL_W];
      in_range  = int'(item.slot) < NUM_TYPES;
      unique case (req_tuser) inside
         REQ_BIND, REQ_RESET_ONE, REQ_SET_DEFAULT: begin
            item.op = in_range ? req_tuser : OP_NOP;
         end
         REQ_RESET_ALL, REQ_FLUSH: begin
            item.op = req_tuser;
         end
         default: begin
            item.op = OP_NOP;
         end
      endcase
   end

   assign req_tready = cnt_ff != QCNT_W'(QUEUE_DEPTH);
   assign push       = req_tvalid && req_tready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item;
      end
   end

   assign head.valid = cnt_ff != '0;
   assign head.work  = slot_ff[rd_ptr_ff];

endmodule

>>> src/dssc_back.sv
// Back end: shadow tables, dirty list sequencer and result register.
module dssc_back #(
   parameter int NUM_TYPES    = dssc_pkg::NUM_TYPES_DEF,
   parameter int HANDLE_WIDTH = dssc_pkg::HANDLE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dssc_pkg::queue_head_type      head,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [0:0]                    rsp_tuser,  // entry_valid
   output logic [dssc_pkg::OUT_DW-1:0]   rsp_tdata,  // changed, change_count, flushed_type,
                                                     // flushed_command, flushed_data
   output logic                          rsp_tlast
);
   import dssc_pkg::*;

   localparam int IW = $clog2(NUM_TYPES);
   localparam int CW = $clog2(NUM_TYPES + 1);
   localparam int SW = HANDLE_WIDTH;
   localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TYPES - 1);
   localparam logic [CW-1:0] N_CNT    = CW'(NUM_TYPES);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CMP    = 3'd1;
   localparam logic [2:0] S_RALL   = 3'd2;
   localparam logic [2:0] S_REPORT = 3'd3;
   localparam logic [2:0] S_FL_ORD = 3'd4;
   localparam logic [2:0] S_FL_ENT = 3'd5;

   // tables
   logic [SW-1:0] ent_cmd_mem [NUM_TYPES];
   logic [SW-1:0] ent_dat_mem [NUM_TYPES];
   logic [SW-1:0] def_cmd_mem [NUM_TYPES];
   logic [SW-1:0] def_dat_mem [NUM_TYPES];
   logic [IW-1:0] ord_mem     [NUM_TYPES];

   logic [NUM_TYPES-1:0] ent_vld_ff, def_vld_ff, ord_vld_ff, dirty_ff;

   // registered read ports
   logic [SW-1:0] ent_cmd_q_ff, ent_dat_q_ff, def_cmd_q_ff, def_dat_q_ff;
   logic          ent_vld_q_ff, def_vld_q_ff, ord_vld_q_ff;
   logic [IW-1:0] ord_q_ff, ord_addr_q_ff;

   // sequencer
   logic [2:0]    state_ff, state_in;
   work_type      cur_ff, cur_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [CW-1:0] chg_cnt_ff, chg_cnt_in;
   logic [IW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] fl_n_ff, fl_n_in;
   logic [CW-1:0] fl_k_ff, fl_k_in;
   logic [IW-1:0] fl_e_ff, fl_e_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_changed_ff;
   logic [CNT_W-1:0]  rsp_count_ff;
   logic              rsp_evld_ff;
   logic [SLOT_W-1:0] rsp_type_ff;
   logic [HDL_W-1:0]  rsp_cmd_ff, rsp_dat_ff;
   logic              rsp_last_ff;

   logic              emit;
   logic              em_changed, em_evld, em_last;
   logic [CNT_W-1:0]  em_count;
   logic [SLOT_W-1:0] em_type;
   logic [HDL_W-1:0]  em_cmd, em_dat;

   logic          out_free;
   logic [IW-1:0] rd_addr, ord_rd_addr;
   logic [SW-1:0] ent_cmd_rd, ent_dat_rd, def_cmd_rd, def_dat_rd;
   logic [IW-1:0] ord_e;
   logic [SW-1:0] new_cmd, new_dat;
   logic [IW-1:0] wa;
   logic          pair_diff, append_ok;
   logic [CW:0]   tail_sum;
   logic [IW-1:0] tail;
   logic [IW-1:0] head_next;
   logic [CW-1:0] n_lim;
   logic          fl_last;

   logic          ent_we, def_we, ord_we, dirty_set, dirty_clr;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign ent_cmd_rd = ent_vld_q_ff ? ent_cmd_q_ff : '0;
   assign ent_dat_rd = ent_vld_q_ff ? ent_dat_q_ff : '0;
   assign def_cmd_rd = def_vld_q_ff ? def_cmd_q_ff : '0;
   assign def_dat_rd = def_vld_q_ff ? def_dat_q_ff : '0;
   // an order slot never written holds its own index
   assign ord_e      = ord_vld_q_ff ? ord_q_ff : ord_addr_q_ff;

   // shared compare of the bound pair against the incoming one
   assign wa        = (state_ff == S_CMP) ? IW'(cur_ff.slot) : idx_ff;
   assign new_cmd   = (state_ff == S_CMP && cur_ff.op == REQ_BIND) ? SW'(cur_ff.cmd) : def_cmd_rd;
   assign new_dat   = (state_ff == S_CMP && cur_ff.op == REQ_BIND) ? SW'(cur_ff.dat) : def_dat_rd;
   assign pair_diff = (ent_cmd_rd != new_cmd) || (ent_dat_rd != new_dat);
   assign append_ok = pair_diff && !dirty_ff[wa] && (count_ff < N_CNT);

   // list is a ring: tail = head + count, wrapped once
   assign tail_sum  = (CW+1)'(head_ff) + (CW+1)'(count_ff);
   assign tail      = IW'((tail_sum >= (CW+1)'(NUM_TYPES)) ?
                          tail_sum - (CW+1)'(NUM_TYPES) : tail_sum);
   assign head_next = (head_ff == LAST_IDX) ? '0 : head_ff + IW'(1);
   assign n_lim     = (int'(count_ff) > MAX_RESULTS) ? CW'(MAX_RESULTS) : count_ff;
   assign fl_last   = (fl_k_ff + CW'(1)) == fl_n_ff;

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      idx_in      = idx_ff;
      chg_cnt_in  = chg_cnt_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      fl_n_in     = fl_n_ff;
      fl_k_in     = fl_k_ff;
      fl_e_in     = fl_e_ff;
      pop         = 1'b0;
      rd_addr     = '0;
      ord_rd_addr = head_ff;
      ent_we      = 1'b0;
      def_we      = 1'b0;
      ord_we      = 1'b0;
      dirty_set   = 1'b0;
      dirty_clr   = 1'b0;
      emit        = 1'b0;
      em_changed  = 1'b0;
      em_count    = '0;
      em_evld     = 1'b0;
      em_type     = '0;
      em_cmd      = '0;
      em_dat      = '0;
      em_last     = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               unique case (head.work.op) inside
                  REQ_BIND, REQ_RESET_ONE: begin
                     pop      = 1'b1;
                     cur_in   = head.work;
                     rd_addr  = IW'(head.work.slot);
                     state_in = S_CMP;
                  end
                  REQ_RESET_ALL: begin
                     pop        = 1'b1;
                     rd_addr    = '0;
                     idx_in     = '0;
                     chg_cnt_in = '0;
                     state_in   = S_RALL;
                  end
                  REQ_FLUSH: begin
                     if (count_ff == '0) begin
                        if (out_free) begin
                           pop  = 1'b1;
                           emit = 1'b1;
                        end
                     end else begin
                        pop         = 1'b1;
                        fl_n_in     = n_lim;
                        fl_k_in     = '0;
                        ord_rd_addr = head_ff;
                        state_in    = S_FL_ORD;
                     end
                  end
                  REQ_SET_DEFAULT: begin
                     if (out_free) begin
                        pop    = 1'b1;
                        def_we = 1'b1;
                        emit   = 1'b1;
                     end
                  end
                  default: begin
                     if (out_free) begin
                        pop  = 1'b1;
                        emit = 1'b1;
                     end
                  end
               endcase
            end
         end
         S_CMP: begin
            rd_addr = IW'(cur_ff.slot);
            if (out_free) begin
               ent_we     = pair_diff;
               emit       = 1'b1;
               em_changed = pair_diff;
               if (append_ok) begin
                  dirty_set = 1'b1;
                  ord_we    = 1'b1;
                  count_in  = count_ff + CW'(1);
               end
               state_in = S_IDLE;
            end
         end
         S_RALL: begin
            ent_we = pair_diff;
            if (pair_diff) begin
               chg_cnt_in = chg_cnt_ff + CW'(1);
            end
            if (append_ok) begin
               dirty_set = 1'b1;
               ord_we    = 1'b1;
               count_in  = count_ff + CW'(1);
            end
            if (idx_ff == LAST_IDX) begin
               state_in = S_REPORT;
            end else begin
               idx_in  = idx_ff + IW'(1);
               rd_addr = idx_ff + IW'(1);
            end
         end
         S_REPORT: begin
            if (out_free) begin
               emit     = 1'b1;
               em_count = CNT_W'(chg_cnt_ff);
               state_in = S_IDLE;
            end
         end
         S_FL_ORD: begin
            fl_e_in  = ord_e;
            rd_addr  = ord_e;
            state_in = S_FL_ENT;
         end
         S_FL_ENT: begin
            rd_addr = fl_e_ff;
            if (out_free) begin
               emit      = 1'b1;
               em_evld   = 1'b1;
               em_count  = CNT_W'(fl_n_ff);
               em_type   = SLOT_W'(fl_e_ff);
               em_cmd    = HDL_W'(ent_cmd_rd);
               em_dat    = HDL_W'(ent_dat_rd);
               em_last   = fl_last;
               dirty_clr = 1'b1;
               head_in   = head_next;
               count_in  = count_ff - CW'(1);
               fl_k_in   = fl_k_ff + CW'(1);
               if (fl_last) begin
                  state_in = S_IDLE;
               end else begin
                  ord_rd_addr = head_next;
                  state_in    = S_FL_ORD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= N_CNT;
         rsp_valid_ff <= 1'b0;
         ent_vld_ff   <= '0;
         def_vld_ff   <= '0;
         ord_vld_ff   <= '0;
         dirty_ff     <= '1;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ent_we) begin
            ent_vld_ff[wa] <= 1'b1;
         end
         if (def_we) begin
            def_vld_ff[IW'(head.work.slot)] <= 1'b1;
         end
         if (ord_we) begin
            ord_vld_ff[tail] <= 1'b1;
         end
         if (dirty_set) begin
            dirty_ff[wa] <= 1'b1;
         end
         if (dirty_clr) begin
            dirty_ff[fl_e_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      idx_ff     <= idx_in;
      chg_cnt_ff <= chg_cnt_in;
      fl_n_ff    <= fl_n_in;
      fl_k_ff    <= fl_k_in;
      fl_e_ff    <= fl_e_in;
      if (emit) begin
         rsp_changed_ff <= em_changed;
         rsp_count_ff   <= em_count;
         rsp_evld_ff    <= em_evld;
         rsp_type_ff    <= em_type;
         rsp_cmd_ff     <= em_cmd;
         rsp_dat_ff     <= em_dat;
         rsp_last_ff    <= em_last;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_cmd_mem[wa] <= new_cmd;
         ent_dat_mem[wa] <= new_dat;
      end
      if (def_we) begin
         def_cmd_mem[IW'(head.work.slot)] <= SW'(head.work.cmd);
         def_dat_mem[IW'(head.work.slot)] <= SW'(head.work.dat);
      end
      if (ord_we) begin
         ord_mem[tail] <= wa;
      end
      ent_cmd_q_ff  <= ent_cmd_mem[rd_addr];
      ent_dat_q_ff  <= ent_dat_mem[rd_addr];
      def_cmd_q_ff  <= def_cmd_mem[rd_addr];
      def_dat_q_ff  <= def_dat_mem[rd_addr];
      ent_vld_q_ff  <= ent_vld_ff[rd_addr];
      def_vld_q_ff  <= def_vld_ff[rd_addr];
      ord_q_ff      <= ord_mem[ord_rd_addr];
      ord_vld_q_ff  <= ord_vld_ff[ord_rd_addr];
      ord_addr_q_ff <= ord_rd_addr;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_evld_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(OUT_DW - 1 - CNT_W - SLOT_W - 2*HDL_W)'(0),
                        rsp_dat_ff, rsp_cmd_ff, rsp_type_ff, rsp_count_ff, rsp_changed_ff};

endmodule

>>> src/dirty_state_shadow_cache.sv
// Dirty-state shadow cache: top level joining the request front end and the table back end.
//
// Requests arrive on req_ (tuser = request kind, tdata = slot and handle pair); results
// leave on rsp_, one beat per bind, reset-one, reset-all, set-default or unknown request,
// and one beat per flushed entry for a flush (one beat if none), the final beat marked by tlast.
// A two-deep queue sits behind the request port, so up to two requests are taken while
// the back end is busy.
// In the back end, bind and reset-one read the table, then compare and write;
// set-default, unknown kinds and an empty flush are answered straight from the queue head;
// reset-all starts the first read, walks one entry per cycle through the single table
// port, then reports; flush reads the list, then the entry, for each flushed entry.
// A request beat is registered into the queue before the back end sees it.
// Results sit in an output register; while rsp_tready is low the back end holds at its
// next result (a reset-all walk still runs) and the queue keeps filling, then req_tready drops.
// After reset every slot holds a zero pair, every slot is dirty and the flush list runs
// 0 .. NUM_TYPES-1; no clearing pass is needed, valid bits stand for the reset contents.
module dirty_state_shadow_cache #(
   parameter int NUM_TYPES    = dssc_pkg::NUM_TYPES_DEF,
   parameter int HANDLE_WIDTH = dssc_pkg::HANDLE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [dssc_pkg::REQ_W-1:0]    req_tuser,  // req_type
   input  logic [dssc_pkg::IN_DW-1:0]    req_tdata,  // state_type, command_handle, data_handle
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [0:0]                    rsp_tuser,  // entry_valid
   output logic [dssc_pkg::OUT_DW-1:0]   rsp_tdata,  // changed, change_count, flushed_type,
                                                     // flushed_command, flushed_data
   output logic                          rsp_tlast
);
   import dssc_pkg::*;

   queue_head_type q_head;
   logic           q_pop;

   dssc_front #(
      .NUM_TYPES (NUM_TYPES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .head       (q_head),
      .pop        (q_pop)
   );

   dssc_back #(
      .NUM_TYPES    (NUM_TYPES),
      .HANDLE_WIDTH (HANDLE_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // back end never pops an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_head.valid)
      else $error("queue popped while empty");

   // only flush entries span several beats
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> rsp_tlast)
      else $error("non-entry result without tlast");

   // queue comes out of reset empty and ready
   a_ready_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> req_tready)
      else $error("request port not ready after reset");

endmodule
